// ===== rtl/tmlr_pkg.sv =====
// Shared types, constants and table builders of the text-mode LCD row refresh core.
`default_nettype none
package tmlr_pkg;

  // Default geometry of the panel
  localparam int COLUMNS_DEF     = 40;
  localparam int ROWS_DEF        = 20;
  localparam int CHAR_HEIGHT_DEF = 12;

  // Widths of the word fields
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int LINE_W   = 5;
  localparam int COLUMN_W = 6;
  localparam int DOTX_W   = 7;
  localparam int DOTY_W   = 6;
  localparam int FADDR_W  = 12;

  // Widest address of either store (64 x 64 cells, 16 x 256 font bytes)
  localparam int ADDR_W = 12;

  // Queue between front and back, result buffer in the back
  localparam int QUEUE_DEPTH  = 2;
  localparam int OFIFO_DEPTH  = 4;

  // Character codes
  localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [BYTE_W-1:0] DOT_BASE   = 8'h80;
  localparam logic [1:0]        DOT_TAG    = 2'b10;

  // Commands, coded as the mode field
  typedef enum logic [MODE_W-1:0] {
    OP_PUT     = 3'd0,
    OP_SETCUR  = 3'd1,
    OP_PLOT    = 3'd2,
    OP_FONT    = 3'd3,
    OP_REFRESH = 3'd4
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT_WR,
    ST_REFRESH
  } bstate_t;

  // Decoded command held in the queue
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;   // cursor, cell or font address
    logic [BYTE_W-1:0] data;   // character, font byte or dot mask
    logic              set;    // dot value
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  // One refresh byte waiting for the panel
  typedef struct packed {
    logic [BYTE_W-1:0] pixels;
    logic              first_line;
    logic              last;
  } out_word_t;

  // Constant quotient and remainder tables over 0..255
  typedef logic [255:0][7:0] tab_t;

  function automatic tab_t quot_tab(input int unsigned d);
    tab_t        t;
    int unsigned q;
    int unsigned r;
    q = 0;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(q);
      r++;
      if (r == d) begin
        r = 0;
        q++;
      end
    end
    return t;
  endfunction

  function automatic tab_t rem_tab(input int unsigned d);
    tab_t        t;
    int unsigned r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(r);
      r++;
      if (r == d) begin
        r = 0;
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tmlr_in_if.sv =====
// Command channel: valid/ready and the fields of one command word.
`default_nettype none
interface tmlr_in_if;
  logic                           valid;
  logic                           ready;
  logic [tmlr_pkg::MODE_W-1:0]    mode;
  logic [tmlr_pkg::BYTE_W-1:0]    data_byte;
  logic [tmlr_pkg::LINE_W-1:0]    text_line;
  logic [tmlr_pkg::COLUMN_W-1:0]  text_column;
  logic [tmlr_pkg::DOTX_W-1:0]    dot_x;
  logic [tmlr_pkg::DOTY_W-1:0]    dot_y;
  logic                           dot_value;
  logic [tmlr_pkg::FADDR_W-1:0]   font_address;

  modport source (output valid, mode, data_byte, text_line, text_column, dot_x, dot_y,
                  dot_value, font_address, input ready);
  modport sink   (input valid, mode, data_byte, text_line, text_column, dot_x, dot_y,
                  dot_value, font_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/tmlr_out_if.sv =====
// Pixel channel: valid/ready and the fields of one pixel word.
`default_nettype none
interface tmlr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tmlr_pkg::BYTE_W-1:0] pixels;
  logic                        first_line;
  logic                        last;

  modport source (output valid, pixels, first_line, last, input ready);
  modport sink   (input valid, pixels, first_line, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tmlr_front.sv =====
// Front end: takes words, drops no-ops and out-of-range ones, decodes addresses.
`default_nettype none
module tmlr_front #(
  parameter int COLUMNS     = tmlr_pkg::COLUMNS_DEF,
  parameter int ROWS        = tmlr_pkg::ROWS_DEF,
  parameter int CHAR_HEIGHT = tmlr_pkg::CHAR_HEIGHT_DEF
) (
  tmlr_in_if.sink          in_ch,
  input  logic             q_full,
  input  logic             clearing,
  output tmlr_pkg::q_wr_t  q_wr
);

  localparam int DOT_ROWS  = 3 * ROWS;
  localparam int DOT_COLS  = 2 * COLUMNS;
  localparam int FONT_SIZE = CHAR_HEIGHT * 256;

  localparam tmlr_pkg::tab_t ColQuot = tmlr_pkg::quot_tab(COLUMNS);
  localparam tmlr_pkg::tab_t ColRem  = tmlr_pkg::rem_tab(COLUMNS);
  localparam tmlr_pkg::tab_t RowRem  = tmlr_pkg::rem_tab(ROWS);
  localparam tmlr_pkg::tab_t Quot3   = tmlr_pkg::quot_tab(3);
  localparam tmlr_pkg::tab_t Rem3    = tmlr_pkg::rem_tab(3);

  logic        accept;
  logic [7:0]  col_q;
  logic [7:0]  col_r;
  logic [7:0]  line_sum;
  logic [7:0]  line_mod;
  logic [12:0] cur_full;
  logic [7:0]  fy;
  logic [7:0]  fy_q;
  logic [7:0]  fy_r;
  logic [2:0]  bit_sh;
  logic [12:0] cell_full;
  logic        dot_ok;
  logic        font_ok;
  logic        keep;

  // Hold off while the queue is full or the character store is being cleared
  assign in_ch.ready = !q_full && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;

  // Cursor: fold surplus columns into the line, then wrap the line
  assign col_q    = ColQuot[{2'b00, in_ch.text_column}];
  assign col_r    = ColRem[{2'b00, in_ch.text_column}];
  assign line_sum = {3'b000, in_ch.text_line} + col_q;
  assign line_mod = RowRem[line_sum];
  assign cur_full = 13'(line_mod) * 13'(COLUMNS) + 13'(col_r);

  // Dot: flip the row, split it into cell row and bit within the cell
  assign dot_ok    = ({2'b00, in_ch.dot_y} <= 8'(DOT_ROWS - 1)) &&
                     ({1'b0, in_ch.dot_x} < 8'(DOT_COLS));
  assign fy        = 8'(DOT_ROWS - 1) - {2'b00, in_ch.dot_y};
  assign fy_q      = Quot3[fy];
  assign fy_r      = Rem3[fy];
  assign bit_sh    = {1'b0, fy_r[1:0]} + (in_ch.dot_x[0] ? 3'd3 : 3'd0);
  assign cell_full = 13'(fy_q) * 13'(COLUMNS) + 13'(in_ch.dot_x[tmlr_pkg::DOTX_W-1:1]);

  // Font byte: drop addresses beyond the font store
  assign font_ok = ({1'b0, in_ch.font_address} < 13'(FONT_SIZE));

  // Classify the word
  always_comb begin
    keep            = 1'b0;
    q_wr.cmd.op     = tmlr_pkg::OP_PUT;
    q_wr.cmd.addr   = '0;
    q_wr.cmd.data   = in_ch.data_byte;
    q_wr.cmd.set    = in_ch.dot_value;
    unique case (in_ch.mode)
      tmlr_pkg::OP_PUT: begin
        keep = 1'b1;
      end
      tmlr_pkg::OP_SETCUR: begin
        keep          = 1'b1;
        q_wr.cmd.op   = tmlr_pkg::OP_SETCUR;
        q_wr.cmd.addr = cur_full[tmlr_pkg::ADDR_W-1:0];
      end
      tmlr_pkg::OP_PLOT: begin
        keep          = dot_ok;
        q_wr.cmd.op   = tmlr_pkg::OP_PLOT;
        q_wr.cmd.addr = cell_full[tmlr_pkg::ADDR_W-1:0];
        q_wr.cmd.data = 8'd1 << bit_sh;
      end
      tmlr_pkg::OP_FONT: begin
        keep          = font_ok;
        q_wr.cmd.op   = tmlr_pkg::OP_FONT;
        q_wr.cmd.addr = in_ch.font_address;
      end
      tmlr_pkg::OP_REFRESH: begin
        keep        = 1'b1;
        q_wr.cmd.op = tmlr_pkg::OP_REFRESH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    q_wr.valid = accept && keep;
  end

endmodule
`default_nettype wire

// ===== rtl/tmlr_queue.sv =====
// Command queue between the front end and the back end.
`default_nettype none
module tmlr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  tmlr_pkg::q_wr_t  q_wr,
  output logic             q_full,
  output tmlr_pkg::q_rd_t  q_rd,
  input  logic             q_pop
);

  localparam int QAW = $clog2(tmlr_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(tmlr_pkg::QUEUE_DEPTH + 1);

  tmlr_pkg::cmd_t   slot_r [tmlr_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             push;
  logic             pop;

  assign q_full     = (cnt_r == QCW'(tmlr_pkg::QUEUE_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.cmd   = slot_r[rd_ptr_r];
  assign push       = q_wr.valid && !q_full;
  assign pop        = q_pop && q_rd.valid;

  // Store the slot
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tmlr_back.sv =====
// Back end: character and font stores, cursor, dot plotting and the row refresh walk.
`default_nettype none
module tmlr_back #(
  parameter int COLUMNS     = tmlr_pkg::COLUMNS_DEF,
  parameter int ROWS        = tmlr_pkg::ROWS_DEF,
  parameter int CHAR_HEIGHT = tmlr_pkg::CHAR_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tmlr_pkg::q_rd_t  q_rd,
  output logic             q_pop,
  output logic             clearing,
  tmlr_out_if.source       out_ch
);

  localparam int TEXT_SIZE = COLUMNS * ROWS;
  localparam int FONT_SIZE = CHAR_HEIGHT * 256;
  localparam int TAW = $clog2(TEXT_SIZE);
  localparam int FAW = $clog2(FONT_SIZE);
  localparam int CW  = $clog2(COLUMNS);
  localparam int PW  = (CHAR_HEIGHT > 1) ? $clog2(CHAR_HEIGHT) : 1;
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OAW = $clog2(tmlr_pkg::OFIFO_DEPTH);
  localparam int OCW = $clog2(tmlr_pkg::OFIFO_DEPTH + 1);

  // Stores
  logic [7:0] text_mem [TEXT_SIZE];
  logic [7:0] font_mem [FONT_SIZE];

  tmlr_pkg::bstate_t state_r, state_nxt;
  logic [TAW-1:0] clr_r, clr_nxt;
  logic [TAW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [PW-1:0]  prow_r, prow_nxt;
  logic [RW-1:0]  crow_r, crow_nxt;
  logic [TAW-1:0] rbase_r, rbase_nxt;
  logic           first_r, first_nxt;
  tmlr_pkg::cmd_t plot_r;

  // Store ports
  logic           txt_we, txt_re;
  logic [TAW-1:0] txt_wa, txt_ra;
  logic [7:0]     txt_wd;
  logic [7:0]     txt_q_r;
  logic           font_we;
  logic [FAW-1:0] font_wa, font_ra;
  logic [7:0]     font_wd;
  logic [7:0]     font_q_r;
  logic [PW+7:0]  font_ra_full;

  // Refresh read pipeline
  logic           issue;
  logic           last_col;
  logic           va_r, va_first_r, va_last_r;
  logic [PW-1:0]  va_prow_r;
  logic           vb_r, vb_first_r, vb_last_r;
  logic [3:0]     inflight;
  logic           credit;

  // Pixel word buffer
  tmlr_pkg::out_word_t ofifo_r [tmlr_pkg::OFIFO_DEPTH];
  logic [OAW-1:0] owr_ptr_r, ord_ptr_r;
  logic [OCW-1:0] ocnt_r;
  logic           opop;

  logic [7:0]     pix_base;

  assign clearing = (state_r == tmlr_pkg::ST_CLEAR);
  assign inflight = 4'(ocnt_r) + 4'(va_r) + 4'(vb_r);
  assign credit   = (inflight < 4'(tmlr_pkg::OFIFO_DEPTH));
  assign last_col = (col_r == CW'(COLUMNS - 1));

  // Cell rewritten by a dot: anything not tagged as a dot cell starts blank
  assign pix_base = (txt_q_r[7:6] == tmlr_pkg::DOT_TAG) ? txt_q_r : tmlr_pkg::DOT_BASE;

  // Sequencer: next state and store controls
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    prow_nxt   = prow_r;
    crow_nxt   = crow_r;
    rbase_nxt  = rbase_r;
    first_nxt  = first_r;
    txt_we     = 1'b0;
    txt_wa     = cursor_r;
    txt_wd     = q_rd.cmd.data;
    txt_re     = 1'b0;
    txt_ra     = rbase_r + TAW'(col_r);
    font_we    = 1'b0;
    font_wa    = q_rd.cmd.addr[FAW-1:0];
    font_wd    = q_rd.cmd.data;
    q_pop      = 1'b0;
    issue      = 1'b0;
    unique case (state_r)
      tmlr_pkg::ST_CLEAR: begin
        txt_we  = 1'b1;
        txt_wa  = clr_r;
        txt_wd  = tmlr_pkg::SPACE_CODE;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TAW'(TEXT_SIZE - 1)) begin
          state_nxt = tmlr_pkg::ST_IDLE;
        end
      end
      tmlr_pkg::ST_IDLE: begin
        if (q_rd.valid) begin
          q_pop = 1'b1;
          unique case (q_rd.cmd.op)
            tmlr_pkg::OP_PUT: begin
              txt_we     = 1'b1;
              cursor_nxt = (cursor_r == TAW'(TEXT_SIZE - 1)) ? '0 : cursor_r + 1'b1;
            end
            tmlr_pkg::OP_SETCUR: begin
              cursor_nxt = q_rd.cmd.addr[TAW-1:0];
            end
            tmlr_pkg::OP_PLOT: begin
              txt_re    = 1'b1;
              txt_ra    = q_rd.cmd.addr[TAW-1:0];
              state_nxt = tmlr_pkg::ST_PLOT_WR;
            end
            tmlr_pkg::OP_FONT: begin
              font_we = 1'b1;
            end
            tmlr_pkg::OP_REFRESH: begin
              col_nxt   = '0;
              state_nxt = tmlr_pkg::ST_REFRESH;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      tmlr_pkg::ST_PLOT_WR: begin
        txt_we    = 1'b1;
        txt_wa    = plot_r.addr[TAW-1:0];
        txt_wd    = plot_r.set ? (pix_base | plot_r.data) : (pix_base & ~plot_r.data);
        state_nxt = tmlr_pkg::ST_IDLE;
      end
      tmlr_pkg::ST_REFRESH: begin
        if (credit) begin
          issue   = 1'b1;
          txt_re  = 1'b1;
          col_nxt = col_r + 1'b1;
          if (last_col) begin
            // Latch the row: advance pixel row, character row and frame flag
            state_nxt = tmlr_pkg::ST_IDLE;
            first_nxt = 1'b0;
            if (prow_r == PW'(CHAR_HEIGHT - 1)) begin
              prow_nxt = '0;
              if (crow_r == RW'(ROWS - 1)) begin
                crow_nxt  = '0;
                rbase_nxt = '0;
                first_nxt = 1'b1;
              end else begin
                crow_nxt  = crow_r + 1'b1;
                rbase_nxt = rbase_r + TAW'(COLUMNS);
              end
            end else begin
              prow_nxt = prow_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = tmlr_pkg::ST_CLEAR;
      end
    endcase
  end

  // Font address from the code just read and the pixel row it was issued with
  assign font_ra_full = {va_prow_r, txt_q_r};
  assign font_ra      = font_ra_full[FAW-1:0];

  // Character store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (txt_we) begin
      text_mem[txt_wa] <= txt_wd;
    end
    if (txt_re) begin
      txt_q_r <= text_mem[txt_ra];
    end
  end

  // Font store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[font_wa] <= font_wd;
    end
    if (va_r) begin
      font_q_r <= font_mem[font_ra];
    end
  end

  // Hold the dot command across its read-modify-write
  always_ff @(posedge clk) begin
    if (q_pop && (q_rd.cmd.op == tmlr_pkg::OP_PLOT)) begin
      plot_r <= q_rd.cmd;
    end
  end

  // Carry row flags alongside the reads
  always_ff @(posedge clk) begin
    va_first_r <= first_r;
    va_last_r  <= last_col;
    va_prow_r  <= prow_r;
    vb_first_r <= va_first_r;
    vb_last_r  <= va_last_r;
  end

  // Pixel word buffer
  assign opop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid      = (ocnt_r != '0);
  assign out_ch.pixels     = ofifo_r[ord_ptr_r].pixels;
  assign out_ch.first_line = ofifo_r[ord_ptr_r].first_line;
  assign out_ch.last       = ofifo_r[ord_ptr_r].last;

  always_ff @(posedge clk) begin
    if (vb_r) begin
      ofifo_r[owr_ptr_r] <= '{pixels: font_q_r, first_line: vb_first_r, last: vb_last_r};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tmlr_pkg::ST_CLEAR;
      clr_r     <= '0;
      cursor_r  <= '0;
      col_r     <= '0;
      prow_r    <= '0;
      crow_r    <= '0;
      rbase_r   <= '0;
      first_r   <= 1'b0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      prow_r   <= prow_nxt;
      crow_r   <= crow_nxt;
      rbase_r  <= rbase_nxt;
      first_r  <= first_nxt;
      va_r     <= issue;
      vb_r     <= va_r;
      if (vb_r) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (opop) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
      ocnt_r <= ocnt_r + OCW'(vb_r) - OCW'(opop);
    end
  end

  // Words in flight never outrun the buffer
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= 4'(tmlr_pkg::OFIFO_DEPTH))
    else $error("pixel buffer overrun");

  // No pixel word while the character store is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmlr_pkg::ST_CLEAR) |-> (ocnt_r == '0 && !va_r && !vb_r))
    else $error("pixel word during clearing pass");

  // The final column of a row is marked last when it reaches the buffer
  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last_col) |=> ##1 (vb_r && vb_last_r))
    else $error("row end not tagged");

  // Pixel row stays within the character height
  a_prow: assert property (@(posedge clk) disable iff (!rst_n)
    prow_r <= PW'(CHAR_HEIGHT - 1))
    else $error("pixel row out of range");

endmodule
`default_nettype wire

// ===== rtl/text_mode_lcd_row_refresh_core.sv =====
// Top level of the text-mode LCD row refresh core.
//
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    mode, data_byte, text_line, text_column, dot_x,
//                               dot_y, dot_value, font_address
//  out_ch   out  valid/ready    pixels, first_line, last
//
// Put char, set cursor and font load are done from the idle state; a dot plot reads
// the character store and then writes it back. A refresh row gives COLUMNS pixel words
// at one a cycle, paced by the character store read port and a four-word pixel buffer;
// out_ch stalls only slow the walk. A two-word command queue feeds the back end.
// After reset the character store is filled with spaces, one cell a cycle, over all
// COLUMNS * ROWS cells (800 by default), with in_ch.ready low meanwhile.
`default_nettype none
module text_mode_lcd_row_refresh_core #(
  parameter int COLUMNS     = tmlr_pkg::COLUMNS_DEF,
  parameter int ROWS        = tmlr_pkg::ROWS_DEF,
  parameter int CHAR_HEIGHT = tmlr_pkg::CHAR_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tmlr_in_if.sink     in_ch,
  tmlr_out_if.source  out_ch
);

  tmlr_pkg::q_wr_t q_wr;
  tmlr_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            q_pop;
  logic            clearing;

  tmlr_front #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .CHAR_HEIGHT (CHAR_HEIGHT)
  ) u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .clearing (clearing),
    .q_wr     (q_wr)
  );

  tmlr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  tmlr_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .CHAR_HEIGHT (CHAR_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the text-mode LCD row refresh core: directed rows, then random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tmlr_pkg::*;

  localparam int COLS         = COLUMNS_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int CHAR_H       = CHAR_HEIGHT_DEF;
  localparam int CELLS        = COLS * ROWS;
  localparam int FONT_BYTES   = CHAR_H * 256;
  localparam int DOT_ROWS     = 3 * ROWS;
  localparam int DOT_COLS     = 2 * COLS;
  localparam int WORD_BUDGET  = 420;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 100;

  // Mode codes the core ignores
  localparam logic [MODE_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] OP_SPARE7 = 3'd7;

  // One command word, plus an optional typed-in expectation for a refresh
  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   data_byte;
    logic [LINE_W-1:0]   text_line;
    logic [COLUMN_W-1:0] text_column;
    logic [DOTX_W-1:0]   dot_x;
    logic [DOTY_W-1:0]   dot_y;
    logic                dot_value;
    logic [FADDR_W-1:0]  font_address;
    bit                  typed;
    logic [BYTE_W-1:0]   row_pixels;
    logic                row_first;
  } lcd_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  tmlr_in_if  in_ch ();
  tmlr_out_if out_ch ();

  text_mode_lcd_row_refresh_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the panel state
  logic [BYTE_W-1:0] text_mem [CELLS];
  logic [BYTE_W-1:0] font_mem [FONT_BYTES];
  bit                font_loaded [FONT_BYTES];
  int unsigned       cursor_pos;
  int unsigned       pix_row;
  int unsigned       text_row;
  bit                frame_start;
  out_word_t         pending_pixels [$];

  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int          errors = 0;
  int          flagged_rows = 0;
  int          stall_left = 0;
  bit          steady = 1'b0;

  function automatic lcd_cmd_t make_cmd(
    input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
    input logic [LINE_W-1:0] line, input logic [COLUMN_W-1:0] column,
    input logic [DOTX_W-1:0] dx, input logic [DOTY_W-1:0] dy, input logic dv,
    input logic [FADDR_W-1:0] faddr);
    lcd_cmd_t c;
    c.mode         = mode;
    c.data_byte    = data;
    c.text_line    = line;
    c.text_column  = column;
    c.dot_x        = dx;
    c.dot_y        = dy;
    c.dot_value    = dv;
    c.font_address = faddr;
    c.typed        = 1'b0;
    c.row_pixels   = '0;
    c.row_first    = 1'b0;
    return c;
  endfunction

  // Refresh whose every byte is known by inspection
  function automatic lcd_cmd_t checked_row(input logic [BYTE_W-1:0] pix);
    lcd_cmd_t c;
    c = make_cmd(OP_REFRESH, 8'h00, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000);
    c.typed      = 1'b1;
    c.row_pixels = pix;
    c.row_first  = 1'b0;
    return c;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : int'($urandom_range(0, 5));
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
  endtask

  // Advance the shadow state by one accepted word; queue any pixel words it causes
  task automatic apply_cmd(input lcd_cmd_t c);
    int unsigned       fy;
    int unsigned       cell_idx;
    int unsigned       addr;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] mask;
    out_word_t         w;
    case (c.mode)
      OP_PUT: begin
        text_mem[cursor_pos] = c.data_byte;
        cursor_pos = (cursor_pos + 1) % CELLS;
      end
      OP_SETCUR: begin
        cursor_pos = (int'(c.text_line) * COLS + int'(c.text_column)) % CELLS;
      end
      OP_PLOT: begin
        // y counts from the bottom; a cell not yet holding dots restarts as blank dots
        if (c.dot_y < DOT_ROWS && c.dot_x < DOT_COLS) begin
          fy = DOT_ROWS - 1 - int'(c.dot_y);
          cell_idx = (fy / 3) * COLS + int'(c.dot_x) / 2;
          code = text_mem[cell_idx];
          if (code[7:6] != DOT_TAG) code = DOT_BASE;
          mask = 8'(1 << (fy % 3));
          if (c.dot_x[0]) mask = mask << 3;
          code = c.dot_value ? (code | mask) : (code & ~mask);
          text_mem[cell_idx] = code;
        end
      end
      OP_FONT: begin
        if (c.font_address < FONT_BYTES) begin
          font_mem[c.font_address]    = c.data_byte;
          font_loaded[c.font_address] = 1'b1;
        end
      end
      OP_REFRESH: begin
        for (int col = 0; col < COLS; col++) begin
          addr = pix_row * 256 + int'(text_mem[text_row * COLS + col]);
          w.pixels     = c.typed ? c.row_pixels : font_mem[addr];
          w.first_line = c.typed ? c.row_first : frame_start;
          w.last       = (col == COLS - 1);
          pending_pixels.push_back(w);
        end
        if (frame_start) flagged_rows++;
        frame_start = 1'b0;
        pix_row++;
        if (pix_row == CHAR_H) begin
          pix_row = 0;
          text_row++;
          if (text_row == ROWS) begin
            text_row    = 0;
            frame_start = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word and hold it until the core takes it
  task automatic push_cmd(input lcd_cmd_t c);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= c.mode;
    in_ch.data_byte    <= c.data_byte;
    in_ch.text_line    <= c.text_line;
    in_ch.text_column  <= c.text_column;
    in_ch.dot_x        <= c.dot_x;
    in_ch.dot_y        <= c.dot_y;
    in_ch.dot_value    <= c.dot_value;
    in_ch.font_address <= c.font_address;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_cmd(c);
    words_sent++;
  endtask

  // Before a refresh, load every font byte the row will read that is still unwritten
  task automatic send_cmd(input lcd_cmd_t c);
    int unsigned addr;
    lcd_cmd_t    f;
    if (c.mode == OP_REFRESH) begin
      for (int col = 0; col < COLS; col++) begin
        addr = pix_row * 256 + int'(text_mem[text_row * COLS + col]);
        if (!font_loaded[addr]) begin
          f = make_cmd(OP_FONT, 8'($urandom), 5'($urandom), 6'($urandom), 7'($urandom),
                       6'($urandom), 1'($urandom), 12'(addr));
          push_cmd(f);
        end
      end
    end
    push_cmd(c);
  endtask

  function automatic lcd_cmd_t random_cmd();
    lcd_cmd_t    c;
    int unsigned pick;
    c = make_cmd(OP_PUT, 8'($urandom), 5'($urandom), 6'($urandom), 7'($urandom),
                 6'($urandom), 1'($urandom), 12'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      c.mode = OP_PUT;
      // Keep mostly to a few codes so font loads stay few
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 5))
          0:       c.data_byte = SPACE_CODE;
          1:       c.data_byte = 8'h41;
          2:       c.data_byte = 8'h00;
          3:       c.data_byte = 8'hff;
          4:       c.data_byte = DOT_BASE;
          default: c.data_byte = 8'h9f;
        endcase
      end
    end else if (pick < 14) begin
      c.mode = OP_SETCUR;
    end else if (pick < 20) begin
      c.mode = OP_PLOT;
      if ($urandom_range(0, 9) != 0) begin
        c.dot_x = 7'($urandom_range(0, DOT_COLS - 1));
        c.dot_y = 6'($urandom_range(0, DOT_ROWS - 1));
      end
    end else if (pick < 23) begin
      c.mode = OP_FONT;
      if ($urandom_range(0, 7) != 0) c.font_address = 12'($urandom_range(0, FONT_BYTES - 1));
    end else if (pick < 98) begin
      c.mode = OP_REFRESH;
    end else begin
      case ($urandom_range(0, 2))
        0:       c.mode = OP_SPARE5;
        1:       c.mode = OP_SPARE6;
        default: c.mode = OP_SPARE7;
      endcase
    end
    return c;
  endfunction

  // Pixel sink: check each word, then stall for a drawn number of cycles
  always @(posedge clk) begin
    int        hold;
    out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", 16'(out_ch.pixels), 16'h0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixels !== want.pixels)
          report_mismatch("pixels", 16'(out_ch.pixels), 16'(want.pixels));
        if (out_ch.first_line !== want.first_line)
          report_mismatch("first_line", 16'(out_ch.first_line), 16'(want.first_line));
        if (out_ch.last !== want.last)
          report_mismatch("last", 16'(out_ch.last), 16'(want.last));
      end
      hold = draw_wait();
      stall_left   <= hold;
      out_ch.ready <= (hold == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    lcd_cmd_t    plan [$];
    lcd_cmd_t    c;
    int unsigned sent;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = '0;
    in_ch.data_byte    = '0;
    in_ch.text_line    = '0;
    in_ch.text_column  = '0;
    in_ch.dot_x        = '0;
    in_ch.dot_y        = '0;
    in_ch.dot_value    = 1'b0;
    in_ch.font_address = '0;

    // Shadow state after reset
    for (int i = 0; i < CELLS; i++) text_mem[i] = SPACE_CODE;
    for (int i = 0; i < FONT_BYTES; i++) begin
      font_mem[i]    = '0;
      font_loaded[i] = 1'b0;
    end
    cursor_pos  = 0;
    pix_row     = 0;
    text_row    = 0;
    frame_start = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: first refreshes of a blank screen, ignored words, wraps, dot cells
    plan.push_back(make_cmd(OP_FONT, 8'hff, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h020));
    plan.push_back(checked_row(8'hff));
    plan.push_back(make_cmd(OP_FONT, 8'ha5, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'hfff));
    plan.push_back(make_cmd(OP_FONT, 8'h00, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h120));
    plan.push_back(checked_row(8'h00));
    plan.push_back(make_cmd(OP_SPARE5, 8'hff, 5'h1f, 6'h3f, 7'h7f, 6'h3f, 1'b1, 12'hfff));
    plan.push_back(make_cmd(OP_SPARE6, 8'hff, 5'h1f, 6'h3f, 7'h7f, 6'h3f, 1'b1, 12'hfff));
    plan.push_back(make_cmd(OP_SPARE7, 8'hff, 5'h1f, 6'h3f, 7'h7f, 6'h3f, 1'b1, 12'hfff));
    plan.push_back(make_cmd(OP_SETCUR, 8'h00, 5'd0, 6'd39, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PUT, 8'h41, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PUT, 8'h42, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_SETCUR, 8'h00, 5'd19, 6'd39, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PUT, 8'h00, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PUT, 8'hff, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_SETCUR, 8'h00, 5'd31, 6'd63, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PUT, 8'h7e, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd0, 6'd59, 1'b1, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd79, 6'd0, 1'b1, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd1, 6'd59, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd0, 6'd59, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd0, 6'd63, 1'b1, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd127, 6'd0, 1'b1, 12'h000));
    plan.push_back(make_cmd(OP_PLOT, 8'h00, 5'd0, 6'd0, 7'd80, 6'd5, 1'b1, 12'h000));
    plan.push_back(make_cmd(OP_FONT, 8'h5a, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    plan.push_back(make_cmd(OP_FONT, 8'hc3, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'hbff));
    plan.push_back(make_cmd(OP_REFRESH, 8'h00, 5'd0, 6'd0, 7'd0, 6'd0, 1'b0, 12'h000));
    foreach (plan[i]) send_cmd(plan[i]);

    // Random words; carry on past a frame wrap so the first-line flag shows up
    sent = 0;
    while (words_sent < WORD_BUDGET || flagged_rows < 1) begin
      if (sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (sent % 150 == 149) begin
        // Drain every outstanding pixel word before sending more
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
      end
      c = random_cmd();
      send_cmd(c);
      sent++;
    end

    in_ch.valid <= 1'b0;
    steady = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tmlr_pkg.sv
rtl/tmlr_in_if.sv
rtl/tmlr_out_if.sv
rtl/tmlr_front.sv
rtl/tmlr_queue.sv
rtl/tmlr_back.sv
rtl/text_mode_lcd_row_refresh_core.sv
tb/testbench.sv
